FILE: design/iabd_pkg.sv
// Shared types, constants and tables of the IMA ADPCM block decoder.
package iabd_pkg;

  localparam int unsigned MAX_BLOCK_BYTES = 32768;
  localparam int unsigned GROUP_SAMPLES   = 8;
  localparam int unsigned HDR_MONO        = 4;
  localparam int unsigned HDR_STEREO      = 8;
  localparam logic [6:0]  MAX_INDEX       = 7'd88;

  localparam int unsigned PADDR_W = 3;
  localparam logic [PADDR_W-1:0] ADDR_CHANNEL_MODE = 3'd0;
  localparam logic [PADDR_W-1:0] ADDR_BLOCK_BYTES  = 3'd4;

  localparam logic [15:0] BLOCK_BYTES_RESET = 16'd1024;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_LAYOUT = 2'd1;
  localparam logic [1:0] STATUS_HEADER = 2'd2;
  localparam logic [1:0] STATUS_TRUNC  = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               channel;
    logic [1:0]         status;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic        channel_mode;
    logic [15:0] block_bytes;
  } cfg_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ERR,
    OP_HDR,
    OP_MONO,
    OP_SLEFT,
    OP_SRIGHT
  } op_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_PRED,
    WR_INDEX
  } wr_t;

  typedef struct packed {
    op_t         op;
    wr_t         wr;
    logic        wr_right;
    logic [15:0] wr_value;
    logic        stereo;
    logic [1:0]  status;
    logic [1:0]  slot;
    logic [7:0]  data;
  } cmd_t;

  localparam logic [14:0] STEP_SIZES [0:88] = '{
    15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14, 15'd16, 15'd17,
    15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31, 15'd34, 15'd37, 15'd41, 15'd45,
    15'd50, 15'd55, 15'd60, 15'd66, 15'd73, 15'd80, 15'd88, 15'd97, 15'd107, 15'd118,
    15'd130, 15'd143, 15'd157, 15'd173, 15'd190, 15'd209, 15'd230, 15'd253, 15'd279,
    15'd307, 15'd337, 15'd371, 15'd408, 15'd449, 15'd494, 15'd544, 15'd598, 15'd658,
    15'd724, 15'd796, 15'd876, 15'd963, 15'd1060, 15'd1166, 15'd1282, 15'd1411,
    15'd1552, 15'd1707, 15'd1878, 15'd2066, 15'd2272, 15'd2499, 15'd2749, 15'd3024,
    15'd3327, 15'd3660, 15'd4026, 15'd4428, 15'd4871, 15'd5358, 15'd5894, 15'd6484,
    15'd7132, 15'd7845, 15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635,
    15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623,
    15'd27086, 15'd29794, 15'd32767
  };

  function automatic logic [14:0] step_size(input logic [6:0] idx);
    logic [6:0] i;
    i = (idx > MAX_INDEX) ? MAX_INDEX : idx;
    return STEP_SIZES[i];
  endfunction

  function automatic logic signed [4:0] index_move(input logic [2:0] mag);
    logic signed [4:0] mv;
    case (mag)
      3'd4:    mv = 5'sd2;
      3'd5:    mv = 5'sd4;
      3'd6:    mv = 5'sd6;
      3'd7:    mv = 5'sd8;
      default: mv = -5'sd1;
    endcase
    return mv;
  endfunction

endpackage

FILE: design/iabd_queue.sv
// Small synchronous queue used between the decoder stages and at the result side.
module iabd_queue
  import iabd_pkg::*;
#(
  parameter int unsigned DEPTH = 4,
  parameter type item_t = logic
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  output logic  full,
  input  item_t wdata,
  input  logic  pop,
  output logic  empty,
  output item_t rdata
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  item_t            store [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: design/iabd_front.sv
// Front stage: tracks the block position, parses headers and classifies each byte.
module iabd_front
  import iabd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  logic     accept,
  input  in_item_t item,
  output logic     cmd_push,
  output cmd_t     cmd
);

  logic [15:0] pos;
  logic [15:0] pos_next;
  logic [7:0]  hdr_low;
  logic [7:0]  hdr_low_next;
  logic        left_big;
  logic        left_big_next;
  logic        right_big;
  logic        right_big_next;
  logic        discarding;
  logic        discarding_next;

  logic        stereo;
  logic [15:0] hdr;
  logic        block_done;
  logic        bad_layout;
  logic        in_hdr;
  logic        hdr_fail;
  logic        idx_big;
  logic [15:0] grp_off;
  logic [7:0]  b;
  logic        end_flag;

  assign stereo     = cfg.channel_mode;
  assign hdr        = stereo ? 16'(HDR_STEREO) : 16'(HDR_MONO);
  assign b          = item.data_byte;
  assign end_flag   = item.stream_end;
  assign block_done = ({1'b0, pos} + 17'd1) >= {1'b0, cfg.block_bytes};
  assign in_hdr     = pos < hdr;
  assign grp_off    = pos - 16'(HDR_STEREO);
  assign idx_big    = b > 8'(MAX_INDEX);

  always_comb begin
    bad_layout = (pos == '0) &&
                 ((cfg.block_bytes < hdr) ||
                  ({1'b0, cfg.block_bytes} > 17'(MAX_BLOCK_BYTES)) ||
                  (stereo && (((cfg.block_bytes - 16'(HDR_STEREO)) &
                               16'(GROUP_SAMPLES - 1)) != '0)));
  end

  always_comb begin
    pos_next        = pos;
    hdr_low_next    = hdr_low;
    left_big_next   = left_big;
    right_big_next  = right_big;
    discarding_next = discarding;
    hdr_fail        = 1'b0;
    cmd             = '0;
    cmd.op          = OP_NONE;
    cmd.wr          = WR_NONE;
    cmd.stereo      = stereo;
    cmd.data        = b;
    cmd.wr_right    = pos[2];

    if (discarding) begin
      if (end_flag) begin
        discarding_next = 1'b0;
        pos_next        = '0;
      end
    end else if (bad_layout) begin
      cmd.op          = OP_ERR;
      cmd.status      = STATUS_LAYOUT;
      pos_next        = '0;
      discarding_next = !end_flag;
    end else begin
      if (in_hdr) begin
        case (pos[1:0])
          2'd0: hdr_low_next = b;
          2'd1: begin
            cmd.wr       = WR_PRED;
            cmd.wr_value = {b, hdr_low};
          end
          2'd2: begin
            cmd.wr       = WR_INDEX;
            cmd.wr_value = {9'd0, idx_big ? MAX_INDEX : b[6:0]};
            if (pos[2]) begin
              right_big_next = idx_big;
            end else begin
              left_big_next = idx_big;
            end
          end
          default: hdr_fail = (pos[2] ? right_big : left_big) || (b != '0);
        endcase
      end

      if (hdr_fail) begin
        cmd.op          = OP_ERR;
        cmd.status      = STATUS_HEADER;
        pos_next        = '0;
        discarding_next = !end_flag;
      end else if (end_flag && !block_done) begin
        cmd.op     = OP_ERR;
        cmd.status = STATUS_TRUNC;
        pos_next   = '0;
      end else begin
        if (in_hdr) begin
          if (pos == hdr - 16'd1) begin
            cmd.op = OP_HDR;
          end
        end else if (!stereo) begin
          cmd.op = OP_MONO;
        end else begin
          cmd.op   = grp_off[2] ? OP_SRIGHT : OP_SLEFT;
          cmd.slot = grp_off[1:0];
        end
        pos_next = (block_done || end_flag) ? '0 : pos + 16'd1;
      end
    end
  end

  assign cmd_push = accept && ((cmd.op != OP_NONE) || (cmd.wr != WR_NONE));

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      hdr_low    <= '0;
      left_big   <= 1'b0;
      right_big  <= 1'b0;
      discarding <= 1'b0;
    end else if (accept) begin
      pos        <= pos_next;
      hdr_low    <= hdr_low_next;
      left_big   <= left_big_next;
      right_big  <= right_big_next;
      discarding <= discarding_next;
    end
  end

endmodule

FILE: design/iabd_back.sv
// Back stage: holds predictors; decodes up to a nibble per unstalled cycle.
module iabd_back
  import iabd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_empty,
  input  cmd_t      cmd,
  output logic      cmd_pop,
  input  logic      res_full,
  output logic      res_push,
  output out_item_t res
);

  localparam int unsigned MEM_AW = $clog2(GROUP_SAMPLES);

  logic signed [15:0] lpred;
  logic signed [15:0] rpred;
  logic [6:0]         lidx;
  logic [6:0]         ridx;
  logic [1:0]         cnt;
  logic signed [15:0] held [GROUP_SAMPLES];

  logic               go;
  logic               do_out;
  logic               last_step;
  logic               dec_en;
  logic               dec_right;
  logic               nib_hi;
  logic               mem_we;

  logic [3:0]         nib;
  logic signed [15:0] pred_in;
  logic [6:0]         idx_in;
  logic [14:0]        step;
  logic [15:0]        diff;
  logic signed [17:0] psum;
  logic signed [15:0] dec_pred;
  logic signed [8:0]  idx_sum;
  logic [6:0]         dec_idx;

  assign go = !cmd_empty && !res_full;

  assign nib     = nib_hi ? cmd.data[7:4] : cmd.data[3:0];
  assign pred_in = dec_right ? rpred : lpred;
  assign idx_in  = dec_right ? ridx : lidx;
  assign step    = step_size(idx_in);

  always_comb begin
    diff = 16'(step >> 3);
    if (nib[0]) diff = diff + 16'(step >> 2);
    if (nib[1]) diff = diff + 16'(step >> 1);
    if (nib[2]) diff = diff + 16'(step);
    if (nib[3]) begin
      psum = 18'(pred_in) - $signed({2'b00, diff});
    end else begin
      psum = 18'(pred_in) + $signed({2'b00, diff});
    end
    if (psum < -18'sd32768) begin
      dec_pred = 16'sh8000;
    end else if (psum > 18'sd32767) begin
      dec_pred = 16'sh7fff;
    end else begin
      dec_pred = psum[15:0];
    end
    idx_sum = $signed({2'b00, idx_in}) + 9'(index_move(nib[2:0]));
    if (idx_sum < 9'sd0) begin
      dec_idx = '0;
    end else if (idx_sum > $signed({2'b00, MAX_INDEX})) begin
      dec_idx = MAX_INDEX;
    end else begin
      dec_idx = idx_sum[6:0];
    end
  end

  always_comb begin
    do_out    = 1'b0;
    last_step = 1'b1;
    dec_en    = 1'b0;
    dec_right = 1'b0;
    nib_hi    = 1'b0;
    mem_we    = 1'b0;
    res       = '0;
    unique case (cmd.op)
      OP_NONE: ;
      OP_ERR: begin
        do_out     = 1'b1;
        res.status = cmd.status;
        res.last   = 1'b1;
      end
      OP_HDR: begin
        do_out = 1'b1;
        if (cnt == 2'd0) begin
          res.sample = lpred;
          res.last   = !cmd.stereo;
          last_step  = !cmd.stereo;
        end else begin
          res.sample  = rpred;
          res.channel = 1'b1;
          res.last    = 1'b1;
        end
      end
      OP_MONO: begin
        do_out     = 1'b1;
        dec_en     = 1'b1;
        nib_hi     = cnt[0];
        res.sample = dec_pred;
        res.last   = cnt[0];
        last_step  = cnt[0];
      end
      OP_SLEFT: begin
        dec_en    = 1'b1;
        nib_hi    = cnt[0];
        mem_we    = 1'b1;
        last_step = cnt[0];
      end
      OP_SRIGHT: begin
        do_out    = 1'b1;
        last_step = (cnt == 2'd3);
        res.last  = (cnt == 2'd3);
        if (cnt[0]) begin
          dec_en      = 1'b1;
          dec_right   = 1'b1;
          nib_hi      = cnt[1];
          res.sample  = dec_pred;
          res.channel = 1'b1;
        end else begin
          res.sample = held[MEM_AW'({cmd.slot, cnt[1]})];
        end
      end
      default: ;
    endcase
  end

  assign cmd_pop  = go && last_step;
  assign res_push = go && do_out;

  always_ff @(posedge clk) begin
    if (go && mem_we) begin
      held[MEM_AW'({cmd.slot, cnt[0]})] <= dec_pred;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      lpred <= '0;
      rpred <= '0;
      lidx  <= '0;
      ridx  <= '0;
    end else if (go) begin
      cnt <= last_step ? 2'd0 : cnt + 2'd1;
      if (cnt == 2'd0) begin
        if (cmd.wr == WR_PRED) begin
          if (cmd.wr_right) begin
            rpred <= cmd.wr_value;
          end else begin
            lpred <= cmd.wr_value;
          end
        end else if (cmd.wr == WR_INDEX) begin
          if (cmd.wr_right) begin
            ridx <= cmd.wr_value[6:0];
          end else begin
            lidx <= cmd.wr_value[6:0];
          end
        end
      end
      if (dec_en) begin
        if (dec_right) begin
          rpred <= dec_pred;
          ridx  <= dec_idx;
        end else begin
          lpred <= dec_pred;
          lidx  <= dec_idx;
        end
      end
    end
  end

endmodule

FILE: design/ima_adpcm_block_decoder_core.sv
// Top level of the IMA ADPCM block decoder: configuration registers and queues.
// Commands pass from the command queue through the back stage to the result queue.
// Bytes are taken one per cycle into a command queue while it is not full; the back
// stage gives one result or nibble per cycle while the result queue has room.
// Data bytes hold two nibbles; stereo right bytes also yield two held left samples.
// A synchronous reset empties both queues, clears position and predictors,
// and sets mono with 1024-byte blocks.
module ima_adpcm_block_decoder_core
  import iabd_pkg::*;
#(
  parameter int unsigned CMD_DEPTH = 4,
  parameter int unsigned RES_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  in_item_t           item,
  output logic               empty,
  input  logic               pop,
  output out_item_t          result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t      cfg;
  logic      accept;
  logic      cmd_push;
  cmd_t      cmd_in;
  logic      cmd_full;
  logic      cmd_empty;
  logic      cmd_pop;
  cmd_t      cmd_head;
  logic      res_push;
  logic      res_full;
  out_item_t res_in;
  logic      cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.channel_mode <= 1'b0;
      cfg.block_bytes  <= BLOCK_BYTES_RESET;
    end else if (cfg_write) begin
      case (paddr)
        ADDR_CHANNEL_MODE: cfg.channel_mode <= pwdata[0];
        ADDR_BLOCK_BYTES:  cfg.block_bytes  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      ADDR_CHANNEL_MODE: prdata = {31'd0, cfg.channel_mode};
      ADDR_BLOCK_BYTES:  prdata = {16'd0, cfg.block_bytes};
      default:           prdata = '0;
    endcase
  end

  assign full   = cmd_full;
  assign accept = push && !cmd_full;

  iabd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .accept   (accept),
    .item     (item),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  iabd_queue #(
    .DEPTH  (CMD_DEPTH),
    .item_t (cmd_t)
  ) u_cmd_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .full  (cmd_full),
    .wdata (cmd_in),
    .pop   (cmd_pop),
    .empty (cmd_empty),
    .rdata (cmd_head)
  );

  iabd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_head),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  iabd_queue #(
    .DEPTH  (RES_DEPTH),
    .item_t (out_item_t)
  ) u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .full  (res_full),
    .wdata (res_in),
    .pop   (pop),
    .empty (empty),
    .rdata (result)
  );

endmodule
